FILE: design/ait_pkg.sv
// Shared types, constants and command codes for the aging ignore table.
`default_nettype none

package ait_pkg;

  localparam int DEFAULT_ENTRIES = 64;

  localparam int KEY_W       = 64;
  localparam int STAMP_W     = 32;
  localparam int CMD_W       = 3;
  localparam int PASSES_W    = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_OUT_W = 7;

  localparam logic [STAMP_W-1:0]  FORGET_TIME_RESET   = 32'd600;
  localparam logic [PASSES_W-1:0] FORGET_PASSES_RESET = 16'd5;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PASS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_FORGET_TIME   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FORGET_PASSES = 2'd1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] time_stamp;
    logic [STAMP_W-1:0] pass_stamp;
  } entry_t;

  typedef struct packed {
    logic key_eq;
    logic expired;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: design/aging_ignore_table_core.sv
// Sequence: tick, clear, unused codes and zero-key inserts go from idle straight to the result word.
// Pass and query scan the table first; insert scans it and then writes the entry.
// The sweep reads one entry per cycle from the read port of the entry RAM.
// Throughput: one item at a time; item_ready is high only while idle.
// Reset (synchronous, rst high): table empty, counters zero, limits 600 and 5.
// The entry RAM needs no clearing pass; valid bits live in flip-flops.
`default_nettype none

module aging_ignore_table_core
  import ait_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire logic [CMD_W-1:0]       command,
  input  wire logic [KEY_W-1:0]       key,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic                        present,
  output logic                        dropped,
  output logic [COUNT_OUT_W-1:0]      entries_in_use
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state, state_next;

  logic [STAMP_W-1:0]  forget_time;
  logic [PASSES_W-1:0] forget_passes;
  logic [STAMP_W-1:0]  tick_count;
  logic [STAMP_W-1:0]  pass_count;
  logic [ENTRIES-1:0]  entry_valid;
  logic [CNT_W-1:0]    entry_count;

  logic [CMD_W-1:0]    op;
  logic [KEY_W-1:0]    op_key;
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    cmp_idx;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    free_idx;
  logic                issuing;
  logic                cmp_vld;
  logic                found;
  logic                free_found;
  logic                drop_flag;

  entry_t              rd_entry;
  entry_t              wr_entry;
  cmp_res_t            cmp_res;
  logic                item_acc;
  logic                cmp_hit;
  logic                scan_end;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic                load_result;

  ait_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(scan_idx),
    .rdata(rd_entry)
  );

  ait_cmp u_cmp (
    .entry        (rd_entry),
    .key          (op_key),
    .tick_count   (tick_count),
    .pass_count   (pass_count),
    .forget_time  (forget_time),
    .forget_passes(forget_passes),
    .res          (cmp_res)
  );

  assign item_acc = item_valid && item_ready;
  assign cmp_hit  = (op != CMD_PASS) && entry_valid[cmp_idx] && cmp_res.key_eq;
  assign scan_end = (state == ST_SCAN) && cmp_vld && (cmp_hit || (cmp_idx == LAST_IDX));

  assign wr_entry.key        = op_key;
  assign wr_entry.time_stamp = tick_count;
  assign wr_entry.pass_stamp = pass_count;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_acc) begin
          case (command)
            CMD_PASS, CMD_QUERY: state_next = ST_SCAN;
            CMD_INSERT:          state_next = (key != '0) ? ST_SCAN : ST_DONE;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = (op == CMD_INSERT) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (load_result) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    item_ready  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = found ? hit_idx : free_idx;
    load_result = 1'b0;
    case (state)
      ST_IDLE:  item_ready  = 1'b1;
      ST_SCAN:  ram_we      = 1'b0;
      ST_WRITE: ram_we      = found || free_found;
      ST_DONE:  load_result = !result_valid || result_ready;
      default:  item_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      forget_time   <= FORGET_TIME_RESET;
      forget_passes <= FORGET_PASSES_RESET;
      tick_count    <= '0;
      pass_count    <= '0;
      entry_valid   <= '0;
      entry_count   <= '0;
      issuing       <= 1'b0;
      cmp_vld       <= 1'b0;
      found         <= 1'b0;
      free_found    <= 1'b0;
      drop_flag     <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_FORGET_TIME:   forget_time   <= cfg_data;
          REG_FORGET_PASSES: forget_passes <= cfg_data[PASSES_W-1:0];
          default:           forget_time   <= forget_time;
        endcase
      end

      if (item_acc) begin
        found      <= 1'b0;
        free_found <= 1'b0;
        drop_flag  <= 1'b0;
        issuing    <= 1'b1;
        cmp_vld    <= 1'b0;
        case (command)
          CMD_TICK: tick_count <= tick_count + 1'b1;
          CMD_CLEAR: begin
            entry_valid <= '0;
            entry_count <= '0;
            pass_count  <= '0;
          end
          CMD_PASS: pass_count <= pass_count + 1'b1;
          default:  pass_count <= pass_count;
        endcase
      end

      if (state == ST_SCAN) begin
        // The read issued last cycle is compared this cycle.
        cmp_vld <= issuing;
        if (issuing && (scan_idx == LAST_IDX)) begin
          issuing <= 1'b0;
        end
        if (cmp_vld) begin
          if (cmp_hit) begin
            found   <= 1'b1;
            hit_idx <= cmp_idx;
          end
          if (!entry_valid[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if ((op == CMD_PASS) && entry_valid[cmp_idx] && cmp_res.expired) begin
            entry_valid[cmp_idx] <= 1'b0;
            entry_count          <= entry_count - 1'b1;
          end
        end
      end

      if (state == ST_WRITE) begin
        if (!found && free_found) begin
          entry_valid[free_idx] <= 1'b1;
          entry_count           <= entry_count + 1'b1;
        end
        drop_flag <= !found && !free_found;
      end

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      op       <= command;
      op_key   <= key;
      scan_idx <= '0;
    end else if ((state == ST_SCAN) && issuing && (scan_idx != LAST_IDX)) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (state == ST_SCAN) begin
      cmp_idx <= scan_idx;
    end
    if (load_result) begin
      present        <= (op == CMD_QUERY) && found;
      dropped        <= (op == CMD_INSERT) && drop_flag;
      entries_in_use <= COUNT_OUT_W'(entry_count);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table size");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (32'(entry_count) == 32'($countones(entry_valid))))
    else $error("entry count disagrees with valid bits");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (item_acc && (command == CMD_CLEAR)) |=> (entry_count == '0) && (entry_valid == '0))
    else $error("clear left entries behind");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_acc |=> !item_ready)
    else $error("accepted a second word without finishing the first");
`endif

endmodule

`default_nettype wire

FILE: design/ait_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ait_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/ait_cmp.sv
// Shared compare unit: key match and age/pass expiry test for one entry.
`default_nettype none

module ait_cmp
  import ait_pkg::*;
(
  input  wire entry_t                entry,
  input  wire logic [KEY_W-1:0]      key,
  input  wire logic [STAMP_W-1:0]    tick_count,
  input  wire logic [STAMP_W-1:0]    pass_count,
  input  wire logic [STAMP_W-1:0]    forget_time,
  input  wire logic [PASSES_W-1:0]   forget_passes,
  output cmp_res_t                   res
);

  logic [STAMP_W-1:0] age;
  logic [STAMP_W-1:0] pass_gap;

  // Both differences wrap modulo 2^32.
  assign age      = tick_count - entry.time_stamp;
  assign pass_gap = pass_count - entry.pass_stamp;

  assign res.key_eq  = (entry.key == key);
  assign res.expired = (age > forget_time) &&
                       (pass_gap > {{(STAMP_W-PASSES_W){1'b0}}, forget_passes});

endmodule

`default_nettype wire
